// ===== rtl/first_fit_chunk_allocator_macros.svh =====
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFCA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ffca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Constants, table entry layout and control types of the chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int HEAP_CHUNKS      = 1024;
	localparam int CHUNK_BYTES      = 32;
	localparam int FIRST_DATA_BYTES = 16;
	localparam int GROW_CHUNKS      = 64;
	localparam int TASK_BITS        = 8;

	localparam int IDX_W       = $clog2(HEAP_CHUNKS);
	localparam int LEN_W       = IDX_W + 1;
	localparam int BYTES_W     = 20;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int NEED_W      = BYTES_W + 2 - CHUNK_SHIFT;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_ALLOC     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE_TASK = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd3;

	// One block descriptor, stored at the block's first chunk.
	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic                 used;
		logic [TASK_BITS-1:0] owner;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PTR_ZERO,
		OP_STEP,
		OP_GROW,
		OP_GROW_MRG,
		OP_MRG_FIRST,
		OP_MRG_EVAL,
		OP_TAKE_REST,
		OP_TAKE,
		OP_FREE_ONE,
		OP_TASK_EVAL,
		OP_SET_STATUS,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [STATUS_W-1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              zero_bytes;
		logic              heap_empty;
		logic              idx_ok;
		logic              grow_ok;
		logic              lt_end;
		logic              fit_ok;
		logic              split;
		logic              at_eq_idx;
		logic              at_gt_idx;
		logic              used;
		logic              out_free;
	} dp_stat_t;

endpackage

// ===== rtl/first_fit_chunk_allocator.sv =====
`timescale 1ns / 1ps
// Zero-size requests, frees past the heap end and kind 3 go from dispatch straight to the result;
// other items walk the blocks (search, merge after growth or free, task scan), one read per block.
// Throughput: one item at a time; the next item is accepted after the previous result is loaded.
// Every block read has a read state that addresses the table, then a state that uses its registered data.
// Reset: arst_n clears the heap to empty and the growth limit to 1024; no table clearing pass.
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator
// First-fit chunk heap allocator with block splitting, growth and coalescing.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator import ffca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [LEN_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,   // request_bytes, block_index, owner_task, zero pad
	input  logic [KIND_W-1:0]    s_tuser,   // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // granted_index, freed_blocks, zero pad
	output logic [STATUS_W-1:0]  m_tuser    // status
);

	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [IDX_W-1:0]     out_granted;
	logic [LEN_W-1:0]     out_freed;

	ffca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffca_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_kind     (s_tuser),
		.in_bytes    (s_tdata[19:0]),
		.in_index    (s_tdata[29:20]),
		.in_task     (s_tdata[37:30]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_status  (m_tuser),
		.out_granted (out_granted),
		.out_freed   (out_freed)
	);

	// Result payload, granted index in the low bits.
	assign m_tdata = {3'b000, out_freed, out_granted};

endmodule

// ===== rtl/ffca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ffca_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath: block table, walk pointer, merge cursor and result register.
// ----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_macros.svh"

module ffca_dp import ffca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 cfg_we,
	input  logic [LEN_W-1:0]     cfg_wdata,
	input  logic [KIND_W-1:0]    in_kind,
	input  logic [BYTES_W-1:0]   in_bytes,
	input  logic [IDX_W-1:0]     in_index,
	input  logic [TASK_BITS-1:0] in_task,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [STATUS_W-1:0]  out_status,
	output logic [IDX_W-1:0]     out_granted,
	output logic [LEN_W-1:0]     out_freed
);

	logic [LEN_W-1:0]     limit_q;
	logic [LEN_W-1:0]     heap_end_q;
	logic [LEN_W-1:0]     ptr_q;
	logic [LEN_W-1:0]     cur_q;
	logic [LEN_W-1:0]     cur_len_q;
	logic                 cur_used_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 zero_q;
	logic [NEED_W-1:0]    need_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TASK_BITS-1:0] task_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IDX_W-1:0]     granted_q;
	logic [LEN_W-1:0]     freed_q;
	logic                 m_valid_q;
	logic [STATUS_W-1:0]  o_status_q;
	logic [IDX_W-1:0]     o_granted_q;
	logic [LEN_W-1:0]     o_freed_q;

	entry_t               rd;
	logic [ENTRY_W-1:0]   rdata;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	entry_t               wentry;
	logic [LEN_W-1:0]     eff_limit;
	logic [LEN_W:0]       grow_sum;
	logic [BYTES_W:0]     round_sum;
	logic [NEED_W-1:0]    need_calc;
	logic [NEED_W-1:0]    rlen_ext;
	logic [LEN_W-1:0]     merge_len;

	assign rd = entry_t'(rdata);

	ffca_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_CHUNKS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ENTRY_W'(wentry)),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Chunk count of an allocate: a short first chunk, then whole chunks.
	assign round_sum = {1'b0, in_bytes} - (BYTES_W+1)'(FIRST_DATA_BYTES)
		+ (BYTES_W+1)'(CHUNK_BYTES - 1);
	assign need_calc = (in_bytes > BYTES_W'(FIRST_DATA_BYTES))
		? NEED_W'(round_sum >> CHUNK_SHIFT) + NEED_W'(1) : NEED_W'(1);

	// Heap bounds and comparisons on the word just read.
	assign eff_limit = (limit_q > LEN_W'(HEAP_CHUNKS)) ? LEN_W'(HEAP_CHUNKS) : limit_q;
	assign grow_sum  = {1'b0, heap_end_q} + (LEN_W+1)'(GROW_CHUNKS);
	assign rlen_ext  = NEED_W'(rd.len);
	assign merge_len = cur_len_q + rd.len;

	always_comb begin
		stat.kind       = kind_q;
		stat.zero_bytes = zero_q;
		stat.heap_empty = (heap_end_q == '0);
		stat.idx_ok     = ({1'b0, idx_q} < heap_end_q);
		stat.grow_ok    = (grow_sum <= {1'b0, eff_limit});
		stat.lt_end     = (ptr_q < heap_end_q);
		stat.fit_ok     = !rd.used && (rlen_ext >= need_q);
		stat.split      = (rlen_ext > need_q);
		stat.at_eq_idx  = (ptr_q == {1'b0, idx_q});
		stat.at_gt_idx  = (ptr_q > {1'b0, idx_q});
		stat.used       = rd.used;
		stat.out_free   = !m_valid_q || m_tready;
	end

	// Table write port.
	always_comb begin
		we     = 1'b0;
		waddr  = ptr_q[IDX_W-1:0];
		wentry = '{len: rd.len, used: 1'b0, owner: '0};
		case (cmd.op)
			OP_GROW, OP_GROW_MRG: begin
				we     = 1'b1;
				waddr  = heap_end_q[IDX_W-1:0];
				wentry = '{len: LEN_W'(GROW_CHUNKS), used: 1'b0, owner: '0};
			end
			OP_MRG_EVAL: begin
				we     = !cur_used_q && !rd.used;
				waddr  = cur_q[IDX_W-1:0];
				wentry = '{len: merge_len, used: 1'b0, owner: '0};
			end
			OP_TAKE_REST: begin
				we     = 1'b1;
				waddr  = ptr_q[IDX_W-1:0] + need_q[IDX_W-1:0];
				wentry = '{len: rd.len - need_q[LEN_W-1:0], used: 1'b0, owner: '0};
			end
			OP_TAKE: begin
				we     = 1'b1;
				wentry = '{len: need_q[LEN_W-1:0], used: 1'b1, owner: task_q};
			end
			OP_FREE_ONE: begin
				we = 1'b1;
			end
			OP_TASK_EVAL: begin
				we = rd.used && (rd.owner == task_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Configuration register and heap size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LEN_W'(HEAP_CHUNKS);
			heap_end_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.op == OP_GROW || cmd.op == OP_GROW_MRG) begin
				heap_end_q <= grow_sum[LEN_W-1:0];
			end
		end
	end

	// Request fields, walk pointer, merge cursor and result fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= '0;
			zero_q     <= 1'b0;
			need_q     <= '0;
			idx_q      <= '0;
			task_q     <= '0;
			status_q   <= ST_OK;
			granted_q  <= '0;
			freed_q    <= '0;
			ptr_q      <= '0;
			cur_q      <= '0;
			cur_len_q  <= '0;
			cur_used_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					kind_q    <= in_kind;
					zero_q    <= (in_bytes == '0);
					need_q    <= need_calc;
					idx_q     <= in_index;
					task_q    <= in_task;
					status_q  <= ST_OK;
					granted_q <= '0;
					freed_q   <= '0;
					ptr_q     <= '0;
				end
				OP_PTR_ZERO, OP_GROW_MRG: begin
					ptr_q <= '0;
				end
				OP_STEP: begin
					ptr_q <= ptr_q + rd.len;
				end
				OP_MRG_FIRST: begin
					cur_q      <= '0;
					cur_len_q  <= rd.len;
					cur_used_q <= rd.used;
					ptr_q      <= rd.len;
				end
				OP_MRG_EVAL: begin
					if (!cur_used_q && !rd.used) begin
						cur_len_q <= merge_len;
						ptr_q     <= cur_q + merge_len;
					end else begin
						cur_q      <= ptr_q;
						cur_len_q  <= rd.len;
						cur_used_q <= rd.used;
						ptr_q      <= ptr_q + rd.len;
					end
				end
				OP_TAKE: begin
					granted_q <= ptr_q[IDX_W-1:0];
				end
				OP_FREE_ONE: begin
					freed_q <= LEN_W'(1);
					ptr_q   <= '0;
				end
				OP_TASK_EVAL: begin
					if (rd.used && (rd.owner == task_q)) begin
						freed_q <= freed_q + LEN_W'(1);
					end
					ptr_q <= ptr_q + rd.len;
				end
				OP_SET_STATUS: begin
					status_q <= cmd.status;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register, free again once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.op == OP_PUBLISH) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			o_status_q  <= status_q;
			o_granted_q <= granted_q;
			o_freed_q   <= freed_q;
		end
	end

	assign m_tvalid    = m_valid_q;
	assign out_status  = o_status_q;
	assign out_granted = o_granted_q;
	assign out_freed   = o_freed_q;

	`FFCA_ASSERT_SAME(a_heap_bound, 1'b1, heap_end_q <= LEN_W'(HEAP_CHUNKS), "heap past its size")
	`FFCA_ASSERT_NEXT(a_grow_step, cmd.op == OP_GROW, heap_end_q == $past(grow_sum[LEN_W-1:0]), "grow step lost")
	`FFCA_ASSERT_SAME(a_ptr_bound, 1'b1, ptr_q <= LEN_W'(HEAP_CHUNKS), "walk pointer past heap")

endmodule

// ===== rtl/ffca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ctrl
// Controller: sequences the walk, split, growth and merge passes of a request.
// ----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_macros.svh"

module ffca_ctrl import ffca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'b00000000000000001,
		S_DISPATCH = 17'b00000000000000010,
		S_GROW0    = 17'b00000000000000100,
		S_FIT_RD   = 17'b00000000000001000,
		S_FIT_EV   = 17'b00000000000010000,
		S_SPLIT    = 17'b00000000000100000,
		S_TAKE     = 17'b00000000001000000,
		S_GROW     = 17'b00000000010000000,
		S_MRG_RD0  = 17'b00000000100000000,
		S_MRG_EV0  = 17'b00000001000000000,
		S_MRG_RD   = 17'b00000010000000000,
		S_MRG_EV   = 17'b00000100000000000,
		S_FREE_RD  = 17'b00001000000000000,
		S_FREE_EV  = 17'b00010000000000000,
		S_TASK_RD  = 17'b00100000000000000,
		S_TASK_EV  = 17'b01000000000000000,
		S_DONE     = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;
	logic   alloc;

	assign alloc    = (stat.kind == KIND_ALLOC);
	assign s_tready = (state_q == S_IDLE);

	// Next state and datapath command.
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				if (alloc) begin
					if (stat.zero_bytes) begin
						cmd.op     = OP_SET_STATUS;
						cmd.status = ST_ZERO_SIZE;
					end else if (stat.heap_empty) begin
						state_d = S_GROW0;
					end else begin
						state_d = S_FIT_RD;
					end
				end else if (stat.kind == KIND_FREE) begin
					if (stat.idx_ok) begin
						state_d = S_FREE_RD;
					end else begin
						cmd.op     = OP_SET_STATUS;
						cmd.status = ST_BAD_FREE;
					end
				end else if (stat.kind == KIND_FREE_TASK) begin
					state_d = S_TASK_RD;
				end
			end
			S_GROW0: begin
				if (stat.grow_ok) begin
					cmd.op  = OP_GROW;
					state_d = S_FIT_RD;
				end else begin
					cmd.op     = OP_SET_STATUS;
					cmd.status = ST_NO_MEM;
					state_d    = S_DONE;
				end
			end
			S_FIT_RD: begin
				state_d = stat.lt_end ? S_FIT_EV : S_GROW;
			end
			S_FIT_EV: begin
				if (stat.fit_ok) begin
					state_d = stat.split ? S_SPLIT : S_TAKE;
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_FIT_RD;
				end
			end
			S_SPLIT: begin
				cmd.op  = OP_TAKE_REST;
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.op  = OP_TAKE;
				state_d = S_DONE;
			end
			S_GROW: begin
				if (stat.grow_ok) begin
					cmd.op  = OP_GROW_MRG;
					state_d = S_MRG_RD0;
				end else begin
					cmd.op     = OP_SET_STATUS;
					cmd.status = ST_NO_MEM;
					state_d    = S_DONE;
				end
			end
			S_MRG_RD0: begin
				state_d = stat.lt_end ? S_MRG_EV0 : S_DONE;
			end
			S_MRG_EV0: begin
				cmd.op  = OP_MRG_FIRST;
				state_d = S_MRG_RD;
			end
			S_MRG_RD: begin
				if (stat.lt_end) begin
					state_d = S_MRG_EV;
				end else if (alloc) begin
					cmd.op  = OP_PTR_ZERO;
					state_d = S_FIT_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MRG_EV: begin
				cmd.op  = OP_MRG_EVAL;
				state_d = S_MRG_RD;
			end
			S_FREE_RD: begin
				if (stat.lt_end) begin
					state_d = S_FREE_EV;
				end else begin
					cmd.op     = OP_SET_STATUS;
					cmd.status = ST_BAD_FREE;
					state_d    = S_DONE;
				end
			end
			S_FREE_EV: begin
				if (stat.at_eq_idx && stat.used) begin
					cmd.op  = OP_FREE_ONE;
					state_d = S_MRG_RD0;
				end else if (stat.at_eq_idx || stat.at_gt_idx) begin
					cmd.op     = OP_SET_STATUS;
					cmd.status = ST_BAD_FREE;
					state_d    = S_DONE;
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_FREE_RD;
				end
			end
			S_TASK_RD: begin
				if (stat.lt_end) begin
					state_d = S_TASK_EV;
				end else begin
					cmd.op  = OP_PTR_ZERO;
					state_d = S_MRG_RD0;
				end
			end
			S_TASK_EV: begin
				cmd.op  = OP_TASK_EVAL;
				state_d = S_TASK_RD;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FFCA_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready, state_q == S_DISPATCH, "accepted item not dispatched")
	`FFCA_ASSERT_NEXT(a_publish_idle, cmd.op == OP_PUBLISH, state_q == S_IDLE, "publish did not return to idle")

endmodule

// ===== test/first_fit_chunk_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_tb
// Self-checking bench for the chunk heap allocator. Requests are driven
// over the input stream, and a software copy of the heap predicts each
// result: allocation with growth and merging, single frees and task frees.
// Results are compared field by field under random idle and stall
// patterns, with the growth limit set to several values.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_tb import ffca_pkg::*; ();

	// Kind code with no operation behind it.
	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    granted;
		logic [LEN_W-1:0]    freed;
	} alloc_result_t;

	// Heap mirror and the queue of results still to arrive.
	class heap_scoreboard;
		int unsigned   blk_len [HEAP_CHUNKS];
		bit            blk_used[HEAP_CHUNKS];
		bit [7:0]      blk_own [HEAP_CHUNKS];
		int unsigned   heap_top;
		int unsigned   grow_limit;
		alloc_result_t pending[$];
		int            errors;

		function new();
			heap_top = 0;
			grow_limit = 1024;
			errors = 0;
		endfunction

		function int unsigned top_limit();
			return (grow_limit < HEAP_CHUNKS) ? grow_limit : HEAP_CHUNKS;
		endfunction

		// Merges each run of free neighbors into its first block.
		function void merge_free();
			int unsigned cur, nxt;
			cur = 0;
			if (heap_top == 0 || blk_len[0] == 0)
				return;
			nxt = blk_len[0];
			while (nxt < heap_top) begin
				if (blk_len[nxt] == 0)
					return;
				if (!blk_used[cur] && !blk_used[nxt])
					blk_len[cur] += blk_len[nxt];
				else
					cur = nxt;
				nxt = cur + blk_len[cur];
			end
		endfunction

		function bit grow();
			if (heap_top + GROW_CHUNKS > top_limit())
				return 0;
			blk_len[heap_top] = GROW_CHUNKS;
			blk_used[heap_top] = 0;
			blk_own[heap_top] = 0;
			heap_top += GROW_CHUNKS;
			return 1;
		endfunction

		function int first_fit(int unsigned need);
			int unsigned at;
			at = 0;
			while (at < heap_top) begin
				if (blk_len[at] == 0)
					return -1;
				if (!blk_used[at] && blk_len[at] >= need)
					return at;
				at += blk_len[at];
			end
			return -1;
		endfunction

		function bit is_start(int unsigned idx);
			int unsigned at;
			at = 0;
			while (at < heap_top) begin
				if (at == idx)
					return 1;
				if (at > idx || blk_len[at] == 0)
					return 0;
				at += blk_len[at];
			end
			return 0;
		endfunction

		// Returns a random block in use, or -1 when none exists.
		function int pick_used();
			int unsigned at;
			int starts[$];
			at = 0;
			while (at < heap_top && blk_len[at] != 0) begin
				if (blk_used[at])
					starts.push_back(at);
				at += blk_len[at];
			end
			if (starts.size() == 0)
				return -1;
			return starts[$urandom_range(0, starts.size() - 1)];
		endfunction

		// Applies one accepted request to the mirror and queues its result.
		function void note_request(logic [KIND_W-1:0] kind, int unsigned bytes,
				int unsigned idx, bit [7:0] task_id);
			alloc_result_t r;
			int unsigned need, at, len;
			int got;
			bit ok;
			r.status = ST_OK;
			r.granted = '0;
			r.freed = '0;
			if (kind == KIND_ALLOC) begin
				if (bytes == 0) begin
					r.status = ST_ZERO_SIZE;
				end else begin
					need = 1;
					ok = 1;
					if (bytes > FIRST_DATA_BYTES)
						need = (bytes - FIRST_DATA_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES + 1;
					if (heap_top == 0)
						ok = grow();
					while (ok) begin
						got = first_fit(need);
						if (got >= 0) begin
							at = got;
							len = blk_len[at];
							if (len > need) begin
								blk_len[at + need] = len - need;
								blk_used[at + need] = 0;
								blk_own[at + need] = 0;
							end
							blk_len[at] = need;
							blk_used[at] = 1;
							blk_own[at] = task_id;
							r.granted = IDX_W'(at);
							break;
						end
						ok = grow();
						if (ok)
							merge_free();
					end
					if (!ok)
						r.status = ST_NO_MEM;
				end
			end else if (kind == KIND_FREE) begin
				if (idx < heap_top && is_start(idx) && blk_used[idx]) begin
					blk_used[idx] = 0;
					blk_own[idx] = 0;
					r.freed = LEN_W'(1);
					merge_free();
				end else begin
					r.status = ST_BAD_FREE;
				end
			end else if (kind == KIND_FREE_TASK) begin
				at = 0;
				while (at < heap_top && blk_len[at] != 0) begin
					if (blk_used[at] && blk_own[at] == task_id) begin
						blk_used[at] = 0;
						blk_own[at] = 0;
						r.freed++;
					end
					at += blk_len[at];
				end
				merge_free();
			end
			pending.push_back(r);
		endfunction

		// Compares one result with the oldest prediction.
		function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] granted,
				logic [LEN_W-1:0] freed);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$error("Result with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (granted !== e.granted) begin
				$error("granted_index: expected %0d, got %0d", e.granted, granted);
				errors++;
			end
			if (freed !== e.freed) begin
				$error("freed_blocks: expected %0d, got %0d", e.freed, freed);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LEN_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [39:0]         s_tdata = '0;    // request_bytes, block_index, owner_task, zero pad
	logic [KIND_W-1:0]   s_tuser = '0;    // kind
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;         // granted_index, freed_blocks, zero pad
	logic [STATUS_W-1:0] m_tuser;         // status

	heap_scoreboard sb = new();
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	first_fit_chunk_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[IDX_W-1:0], m_tdata[IDX_W +: LEN_W]);
	end

	// Offers one item, with a random gap first, and waits for its acceptance.
	task automatic send_item(logic [KIND_W-1:0] kind, int unsigned bytes,
			int unsigned idx, bit [7:0] task_id);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, task_id, idx[IDX_W-1:0], bytes[BYTES_W-1:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(kind, bytes, idx, task_id);
	endtask

	// Waits until every result is in and the block has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(int unsigned value);
		cfg_we <= 1'b1;
		cfg_wdata <= LEN_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.grow_limit = value;
	endtask

	// One random request, mostly well formed against the current heap.
	task automatic random_item();
		int sel, blk;
		int unsigned bytes;
		bit [7:0] task_id;
		sel = $urandom_range(0, 99);
		task_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 7));
		if (sel < 50) begin
			case ($urandom_range(0, 19))
				0: bytes = 0;
				1: bytes = $urandom_range(0, 1048575);
				2, 3, 4: bytes = $urandom_range(1, 4000);
				default: bytes = $urandom_range(1, 400);
			endcase
			send_item(KIND_ALLOC, bytes, $urandom_range(0, 1023), task_id);
		end else if (sel < 80) begin
			blk = sb.pick_used();
			if (blk < 0)
				blk = $urandom_range(0, 1023);
			send_item(KIND_FREE, $urandom_range(0, 1048575), blk, task_id);
		end else if (sel < 88) begin
			send_item(KIND_FREE, $urandom_range(0, 1048575), $urandom_range(0, 1023), task_id);
		end else if (sel < 96) begin
			send_item(KIND_FREE_TASK, $urandom_range(0, 1048575), $urandom_range(0, 1023),
				task_id);
		end else begin
			send_item(KIND_RESERVED, $urandom_range(0, 1048575), $urandom_range(0, 1023),
				task_id);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size extremes, bad frees, task frees and the unused kind.
		send_item(KIND_FREE, 0, 0, 0);
		send_item(KIND_ALLOC, 0, 0, 1);
		send_item(KIND_ALLOC, 1, 1023, 255);
		send_item(KIND_ALLOC, 16, 0, 2);
		send_item(KIND_ALLOC, 17, 0, 2);
		send_item(KIND_ALLOC, 48, 0, 3);
		send_item(KIND_ALLOC, 49, 0, 3);
		send_item(KIND_ALLOC, 1048575, 0, 4);
		send_item(KIND_ALLOC, 2000, 0, 5);
		send_item(KIND_FREE, 0, 1023, 0);
		send_item(KIND_FREE, 0, 2, 0);
		send_item(KIND_FREE, 0, 1, 0);
		send_item(KIND_FREE, 0, 1, 0);
		send_item(KIND_FREE, 0, 0, 0);
		send_item(KIND_FREE_TASK, 0, 0, 2);
		send_item(KIND_FREE_TASK, 0, 0, 200);
		send_item(KIND_RESERVED, 1048575, 1023, 255);
		send_item(KIND_FREE_TASK, 0, 0, 255);
		drain();

		// Limit zero: the heap cannot grow any further.
		write_limit(0);
		send_item(KIND_ALLOC, 100, 0, 1);
		drain();

		// Random phases over several limits and idle patterns.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_limit(64);
				1: write_limit(2047);
				2: write_limit(300);
				3: write_limit(1024);
				4: write_limit(128);
				default: write_limit(1024);
			endcase
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < 105; n++) begin
				if (ph == 3 && n == 10)
					hold_req++;
				random_item();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#500ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
